/* src/dcc_pkg.sv */
`timescale 1ns / 1ps

package dcc_pkg;

   // Operation codes carried on the request channel's tuser.
   localparam logic [1:0] OP_POSITION = 2'd0;
   localparam logic [1:0] OP_INSTR    = 2'd1;
   localparam logic [1:0] OP_JUMP     = 2'd2;
   localparam logic [1:0] OP_RESTART  = 2'd3;

   // Result kinds carried on the response channel's tuser.
   localparam logic [1:0] KIND_FETCH = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_PAUSE = 2'd2;
   localparam logic [1:0] KIND_DONE  = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_COPPER_ENABLED = 2'd0;
   localparam logic [1:0] CSR_DANGER_LEVEL   = 2'd1;
   localparam logic [1:0] CSR_LIST_START     = 2'd2;

   // Defaults for the top-level parameters.
   localparam int LINE_PIXELS_DEFAULT     = 512;
   localparam int MAX_PER_SEGMENT_DEFAULT = 57;

   // Depth of the result queue; it must hold two items beyond the in-flight one.
   localparam int RSP_QUEUE_DEPTH = 4;

   // Field widths.
   localparam int ADDR_W  = 24;
   localparam int WORD_W  = 16;
   localparam int XPIX_W  = 10;
   localparam int LINE_W  = 9;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_DATA_W = 24;

   typedef struct packed {
      logic [1:0]        op;
      logic [XPIX_W-1:0] x_pixel;
      logic [LINE_W-1:0] line;
      logic              blitter_busy;
      logic [WORD_W-1:0] first_word;
      logic [WORD_W-1:0] second_word;
      logic [ADDR_W-1:0] jump_address;
   } dcc_item_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] address;
      logic [WORD_W-1:0] data;
      logic [XPIX_W-1:0] end_x;
      logic              last;
   } dcc_result_type;

   typedef struct packed {
      logic              copper_enabled;
      logic [2:0]        danger_level;
      logic [ADDR_W-1:0] list_start;
   } dcc_cfg_type;

   // Builds one result item.
   function automatic dcc_result_type make_result(input logic [1:0]        kind,
                                                  input logic [ADDR_W-1:0] address,
                                                  input logic [WORD_W-1:0] data,
                                                  input logic [XPIX_W-1:0] end_x,
                                                  input logic              last);
      dcc_result_type r;
      r.kind    = kind;
      r.address = address;
      r.data    = data;
      r.end_x   = end_x;
      r.last    = last;
      return r;
   endfunction

endpackage

/* src/dcc_seq.sv */
`timescale 1ns / 1ps

module dcc_seq #(
   parameter int LINE_PIXELS     = dcc_pkg::LINE_PIXELS_DEFAULT,
   parameter int MAX_PER_SEGMENT = dcc_pkg::MAX_PER_SEGMENT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  dcc_pkg::dcc_item_type  item,
   input  dcc_pkg::dcc_cfg_type   cfg,
   output logic [1:0]             res_count,
   output dcc_pkg::dcc_result_type res0,
   output dcc_pkg::dcc_result_type res1
);
   import dcc_pkg::*;

   // Highest color clock a wait can still reach on the current line.
   localparam logic [9:0] REACH_CLOCK = 10'((LINE_PIXELS - 1) / 2);
   localparam logic [5:0] SEG_LIMIT   = 6'(MAX_PER_SEGMENT);

   typedef struct packed {
      dcc_result_type    res;
      logic              waiting;
      logic              wait_blitter;
      logic [ADDR_W-1:0] pc;
   } check_type;

   // Sequencer state.
   logic [ADDR_W-1:0] pc_ff, pc_in;
   logic              waiting_ff, waiting_in;
   logic [7:0]        wait_line_ff, wait_line_in;
   logic [7:0]        wait_clock_ff, wait_clock_in;
   logic              wait_blitter_ff, wait_blitter_in;
   logic [9:0]        beam_clock_ff, beam_clock_in;
   logic [7:0]        beam_line_ff, beam_line_in;
   logic [5:0]        count_ff, count_in;

   // Fetches at pc; a pending wait may end the line, pause, or pass first.
   function automatic check_type check_wait(input logic              waiting,
                                            input logic [7:0]        wl,
                                            input logic [7:0]        wc,
                                            input logic              wb,
                                            input logic [7:0]        bl,
                                            input logic [9:0]        bc,
                                            input logic [ADDR_W-1:0] pc,
                                            input logic              busy);
      check_type c;
      c.waiting      = waiting;
      c.wait_blitter = wb;
      c.pc           = pc;
      c.res          = make_result(KIND_FETCH, pc, '0, '0, 1'b1);
      if (waiting) begin
         if (bl < wl) begin
            c.res = make_result(KIND_DONE, '0, '0, '0, 1'b1);
         end else if (bl == wl && bc < {2'b00, wc}) begin
            if ({2'b00, wc} > REACH_CLOCK) begin
               c.res = make_result(KIND_DONE, '0, '0, '0, 1'b1);
            end else begin
               c.res = make_result(KIND_PAUSE, '0, '0, {1'b0, wc, 1'b0}, 1'b1);
            end
         end else if (wb && busy) begin
            c.res = make_result(KIND_DONE, '0, '0, '0, 1'b1);
         end else begin
            c.wait_blitter = 1'b0;
            c.waiting      = 1'b0;
            c.pc           = pc + ADDR_W'(4);
            c.res          = make_result(KIND_FETCH, c.pc, '0, '0, 1'b1);
         end
      end
      return c;
   endfunction

   // Executes one item against the current state.
   always_comb begin
      logic [WORD_W-1:0] w1;
      logic [WORD_W-1:0] w2;
      logic [8:0]        reg_ofs;
      logic [7:0]        cond_line;
      logic [7:0]        cond_clock;
      logic              cond_blitter;
      logic              early;
      logic              protect;
      logic              second;
      dcc_result_type    tail;
      check_type         chk;

      w1           = item.first_word;
      w2           = item.second_word;
      reg_ofs      = {w1[8:1], 1'b0};
      cond_line    = w1[15:8] & {1'b1, w2[14:8]};
      cond_clock   = w1[7:0] & w2[7:0] & 8'hfe;
      cond_blitter = ~w2[15];
      early        = 1'b0;
      protect      = 1'b0;
      second       = 1'b0;
      tail         = make_result(KIND_DONE, '0, '0, '0, 1'b1);
      chk          = '0;

      pc_in           = pc_ff;
      waiting_in      = waiting_ff;
      wait_line_in    = wait_line_ff;
      wait_clock_in   = wait_clock_ff;
      wait_blitter_in = wait_blitter_ff;
      beam_clock_in   = beam_clock_ff;
      beam_line_in    = beam_line_ff;
      count_in        = count_ff;
      res_count       = 2'd0;
      res0            = make_result(KIND_DONE, '0, '0, '0, 1'b1);
      res1            = make_result(KIND_DONE, '0, '0, '0, 1'b1);

      case (item.op)
         OP_JUMP: begin
            pc_in      = item.jump_address;
            waiting_in = 1'b0;
         end
         OP_RESTART: begin
            pc_in      = cfg.list_start;
            waiting_in = 1'b0;
         end
         OP_POSITION: begin
            beam_clock_in = {1'b0, item.x_pixel[9:1]};
            beam_line_in  = item.line[7:0];
            count_in      = '0;
            res_count     = 2'd1;
            if (cfg.copper_enabled) begin
               chk = check_wait(waiting_ff, wait_line_ff, wait_clock_ff, wait_blitter_ff,
                                beam_line_in, beam_clock_in, pc_ff, item.blitter_busy);
               res0            = chk.res;
               waiting_in      = chk.waiting;
               wait_blitter_in = chk.wait_blitter;
               pc_in           = chk.pc;
            end
         end
         OP_INSTR: begin
            if (!cfg.copper_enabled || waiting_ff || count_ff >= SEG_LIMIT) begin
               res_count = 2'd1;
            end else begin
               // Execute MOVE, WAIT or SKIP.
               if (!w1[0]) begin
                  pc_in = pc_ff + ADDR_W'(4);
                  if (({1'b0, reg_ofs} + {2'b00, cfg.danger_level, 5'b00000}) < 10'h080) begin
                     protect       = 1'b1;
                     waiting_in    = 1'b1;
                     wait_line_in  = 8'hff;
                     wait_clock_in = 8'hfe;
                  end else begin
                     second = 1'b1;
                     res0   = make_result(KIND_WRITE, ADDR_W'(reg_ofs), w2, '0, 1'b0);
                  end
               end else if (!w2[0]) begin
                  waiting_in      = 1'b1;
                  wait_line_in    = cond_line;
                  wait_clock_in   = cond_clock;
                  wait_blitter_in = cond_blitter;
               end else begin
                  early = (beam_line_ff < cond_line)
                       || (beam_line_ff == cond_line && beam_clock_ff < {2'b00, cond_clock})
                       || (cond_blitter && item.blitter_busy);
                  pc_in = pc_ff + (early ? ADDR_W'(4) : ADDR_W'(8));
               end

               if (protect) begin
                  res_count = 2'd1;
               end else begin
                  // Advance beam and segment count; below the limit, check or fetch.
                  beam_clock_in = beam_clock_ff + 10'd4;
                  count_in      = count_ff + 6'd1;
                  if (count_in < SEG_LIMIT) begin
                     chk = check_wait(waiting_in, wait_line_in, wait_clock_in,
                                      wait_blitter_in, beam_line_ff, beam_clock_in,
                                      pc_in, item.blitter_busy);
                     tail            = chk.res;
                     waiting_in      = chk.waiting;
                     wait_blitter_in = chk.wait_blitter;
                     pc_in           = chk.pc;
                  end
                  if (second) begin
                     res1      = tail;
                     res_count = 2'd2;
                  end else begin
                     res0      = tail;
                     res_count = 2'd1;
                  end
               end
            end
         end
         default: begin
            res_count = 2'd0;
         end
      endcase
   end

   // State update on each processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff           <= '0;
         waiting_ff      <= 1'b0;
         wait_line_ff    <= '0;
         wait_clock_ff   <= '0;
         wait_blitter_ff <= 1'b0;
         beam_clock_ff   <= '0;
         beam_line_ff    <= '0;
         count_ff        <= '0;
      end else if (step) begin
         pc_ff           <= pc_in;
         waiting_ff      <= waiting_in;
         wait_line_ff    <= wait_line_in;
         wait_clock_ff   <= wait_clock_in;
         wait_blitter_ff <= wait_blitter_in;
         beam_clock_ff   <= beam_clock_in;
         beam_line_ff    <= beam_line_in;
         count_ff        <= count_in;
      end
   end

endmodule

/* src/dcc_rsp_queue.sv */
`timescale 1ns / 1ps

module dcc_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              push_count,
   input  dcc_pkg::dcc_result_type push0,
   input  dcc_pkg::dcc_result_type push1,
   output logic                    room2,
   output logic                    out_valid,
   input  logic                    out_ready,
   output dcc_pkg::dcc_result_type out_item
);
   import dcc_pkg::*;

   localparam int PTR_W = $clog2(RSP_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(RSP_QUEUE_DEPTH + 1);

   dcc_result_type   q_ff [RSP_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   logic [PTR_W-1:0] wr_next;

   assign out_valid = (count_ff != '0);
   assign out_item  = q_ff[rd_ptr_ff];
   assign room2     = (count_ff <= CNT_W'(RSP_QUEUE_DEPTH - 2));
   assign pop       = out_valid && out_ready;
   assign wr_next   = wr_ptr_ff + PTR_W'(1);

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage: up to two items written per cycle.
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         q_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         q_ff[wr_next] <= push1;
      end
   end

endmodule

/* src/display_copper_coprocessor.sv */
`timescale 1ns / 1ps
// Items are held in the input register and results in the result queue.
// Items go in one per cycle while the queue has room for two, results leave one
// per cycle while rsp is ready; a write followed by a fetch or line end gives two.
// The four-entry result queue sets how far req runs ahead of a stalled rsp side.
// Reset (synchronous, active high) clears sequencer, config and queue pointers.
module display_copper_coprocessor #(
   parameter int LINE_PIXELS     = dcc_pkg::LINE_PIXELS_DEFAULT,
   parameter int MAX_PER_SEGMENT = dcc_pkg::MAX_PER_SEGMENT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tdata: x_pixel[9:0], line[18:10], blitter_busy[19], first_word[35:20],
   //        second_word[51:36], jump_address[75:52], zero fill [79:76]
   input  logic [dcc_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: op[1:0]
   input  logic [1:0]                     req_tuser,
   // Result channel.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tdata: address[23:0], data[39:24], end_x[49:40], zero fill [55:50]
   output logic [dcc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: kind[1:0]
   output logic [1:0]                     rsp_tuser,
   output logic                           rsp_tlast,
   // Configuration write port.
   input  logic                           csr_we,
   input  logic [1:0]                     csr_index,
   input  logic [dcc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dcc_pkg::*;

   dcc_cfg_type    cfg_ff;
   dcc_item_type   item_ff;
   logic           item_valid_ff;
   logic           step;
   logic           room2;
   logic [1:0]     res_count;
   logic [1:0]     push_count;
   dcc_result_type res0;
   dcc_result_type res1;
   dcc_result_type out_item;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COPPER_ENABLED: cfg_ff.copper_enabled <= csr_wdata[0];
            CSR_DANGER_LEVEL:   cfg_ff.danger_level   <= csr_wdata[2:0];
            CSR_LIST_START:     cfg_ff.list_start     <= csr_wdata[ADDR_W-1:0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Input register; the held item is processed once the queue has room for two.
   assign step       = item_valid_ff && room2;
   assign req_tready = !item_valid_ff || step;
   assign push_count = step ? res_count : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.op           <= req_tuser;
         item_ff.x_pixel      <= req_tdata[9:0];
         item_ff.line         <= req_tdata[18:10];
         item_ff.blitter_busy <= req_tdata[19];
         item_ff.first_word   <= req_tdata[35:20];
         item_ff.second_word  <= req_tdata[51:36];
         item_ff.jump_address <= req_tdata[75:52];
      end
   end

   dcc_seq #(
      .LINE_PIXELS     (LINE_PIXELS),
      .MAX_PER_SEGMENT (MAX_PER_SEGMENT)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (item_ff),
      .cfg       (cfg_ff),
      .res_count (res_count),
      .res0      (res0),
      .res1      (res1)
   );

   dcc_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (res0),
      .push1      (res1),
      .room2      (room2),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (out_item)
   );

   // Result packing.
   assign rsp_tdata = {6'b000000, out_item.end_x, out_item.data, out_item.address};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.last;

endmodule
